// File: rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/rar_pkg.sv
`default_nettype none
package rar_pkg;
   localparam int OperandWidthDefault = 16;
   localparam int NumWidth = 33;
   localparam int DenWidth = 31;
   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic sum_step;
      logic gcd_init;
      logic gcd_step;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic num_zero;
      logic gcd_done;
      logic div_done;
   } status_type;
endpackage
`default_nettype wire

// File: rtl/core/rar_datapath.sv
`default_nettype none
module rar_datapath #(
   parameter int OPERAND_WIDTH = rar_pkg::OperandWidthDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rar_pkg::cmd_type     cmd,
   output rar_pkg::status_type       status,
   input  wire logic [1:0]           req_mode,
   input  wire logic [15:0]          req_a_num,
   input  wire logic [15:0]          req_a_den,
   input  wire logic [15:0]          req_b_num,
   input  wire logic [15:0]          req_b_den,
   output logic signed [32:0]        rsp_res_num,
   output logic [30:0]               rsp_res_den,
   output logic                      rsp_div_zero
);
   localparam int W = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int SW = PW + 1;
   localparam int CW = $clog2(SW + 1);

   logic [1:0]    mode_ff;
   logic [W-1:0]  pm_ff, qm_ff, rm_ff, sm_ff;
   logic          pn_ff, qn_ff, rn_ff, sn_ff;
   logic [PW-1:0] x_ff, y_ff, dm_ff;
   logic          xn_ff, yn_ff, dn_ff;
   logic [SW-1:0] nm_ff;
   logic          nn_ff;
   logic [SW-1:0] ga_ff, gb_ff;
   logic [CW-1:0] gk_ff;
   logic [SW-1:0] quo_ff, rem_ff, dvd_ff, dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          sel_ff;
   logic [SW-1:0] qn_res_ff;
   logic          dz_ff;

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      mag = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   logic [W-1:0] a_n, a_d, b_n, b_d;
   assign a_n = W'(req_a_num);
   assign a_d = W'(req_a_den);
   assign b_n = W'(req_b_num);
   assign b_d = W'(req_b_den);

   logic [SW-1:0] sum_mag;
   logic          sum_neg, yneg_eff;
   always_comb begin
      yneg_eff = (mode_ff == rar_pkg::MODE_SUB) ? ~yn_ff : yn_ff;
      if (xn_ff == yneg_eff) begin
         sum_mag = {1'b0, x_ff} + {1'b0, y_ff};
         sum_neg = xn_ff;
      end else if (x_ff >= y_ff) begin
         sum_mag = {1'b0, x_ff - y_ff};
         sum_neg = xn_ff;
      end else begin
         sum_mag = {1'b0, y_ff - x_ff};
         sum_neg = yneg_eff;
      end
   end

   logic [SW:0] trial;
   assign trial = {rem_ff, dvd_ff[SW-1]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         pm_ff <= mag(a_n); pn_ff <= a_n[W-1];
         qm_ff <= mag(a_d); qn_ff <= a_d[W-1];
         rm_ff <= mag(b_n); rn_ff <= b_n[W-1];
         sm_ff <= mag(b_d); sn_ff <= b_d[W-1];
      end
      if (cmd.mul_step) begin
         case (mode_ff)
            rar_pkg::MODE_MUL: begin
               x_ff <= pm_ff * rm_ff; xn_ff <= pn_ff ^ rn_ff;
               y_ff <= '0; yn_ff <= 1'b0;
               dm_ff <= qm_ff * sm_ff; dn_ff <= qn_ff ^ sn_ff;
            end
            rar_pkg::MODE_DIV: begin
               x_ff <= pm_ff * sm_ff; xn_ff <= pn_ff ^ sn_ff;
               y_ff <= '0; yn_ff <= 1'b0;
               dm_ff <= qm_ff * rm_ff; dn_ff <= qn_ff ^ rn_ff;
            end
            default: begin
               x_ff <= pm_ff * sm_ff; xn_ff <= pn_ff ^ sn_ff;
               y_ff <= rm_ff * qm_ff; yn_ff <= rn_ff ^ qn_ff;
               dm_ff <= qm_ff * sm_ff; dn_ff <= qn_ff ^ sn_ff;
            end
         endcase
      end
      if (cmd.sum_step) begin
         nm_ff <= sum_mag;
         nn_ff <= (sum_neg ^ dn_ff) & (sum_mag != '0);
      end
      // binary gcd, common factors of two counted in gk_ff
      if (cmd.gcd_init) begin
         ga_ff <= nm_ff;
         gb_ff <= {1'b0, dm_ff};
         gk_ff <= '0;
      end else if (cmd.gcd_step) begin
         if (!ga_ff[0] && !gb_ff[0]) begin
            ga_ff <= ga_ff >> 1;
            gb_ff <= gb_ff >> 1;
            gk_ff <= gk_ff + 1'b1;
         end else if (!ga_ff[0]) ga_ff <= ga_ff >> 1;
         else if (!gb_ff[0]) gb_ff <= gb_ff >> 1;
         else if (ga_ff > gb_ff) ga_ff <= ga_ff - gb_ff;
         else gb_ff <= gb_ff - ga_ff;
      end
      if (cmd.div_init) begin
         dvd_ff <= sel_ff ? {1'b0, dm_ff} : nm_ff;
         dvs_ff <= ga_ff << gk_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[SW-2:0], ~trial[SW]};
         rem_ff <= trial[SW] ? {rem_ff[SW-2:0], dvd_ff[SW-1]} : trial[SW-1:0];
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.finish) begin
         if (!sel_ff) qn_res_ff <= dvd_ff;
         else begin
            rsp_res_den <= 31'(dvd_ff);
            rsp_res_num <= nn_ff ? -$signed(33'(qn_res_ff)) : $signed(33'(qn_res_ff));
            rsp_div_zero <= 1'b0;
         end
      end
      if (cmd.sum_step && dm_ff == '0) begin
         rsp_res_num <= '0; rsp_res_den <= '0; rsp_div_zero <= 1'b1;
      end else if (cmd.sum_step && sum_mag == '0) begin
         rsp_res_num <= '0; rsp_res_den <= 31'd1; rsp_div_zero <= 1'b0;
      end
      if (reset) sel_ff <= 1'b0;
      else if (cmd.finish) sel_ff <= ~sel_ff;
      dz_ff <= (dm_ff == '0);
   end

   assign status.den_zero = dz_ff | (dm_ff == '0);
   assign status.num_zero = (nm_ff == '0);
   assign status.gcd_done = (ga_ff == gb_ff);
   assign status.div_done = (cnt_ff == CW'(SW));
endmodule
`default_nettype wire

// File: rtl/core/rar_control.sv
`default_nettype none
`include "assert_macros.svh"
module rar_control (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rar_pkg::cmd_type     cmd,
   input  wire rar_pkg::status_type status
);
   localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_SUM = 3'd2, S_CHK = 3'd3,
                          S_GCD = 3'd4, S_DIVI = 3'd5, S_DIV = 3'd6, S_OUT = 3'd7;
   logic [2:0] state_ff, state_in;
   logic       second_ff, second_in;
   logic       rv_ff, rv_in;

   always_comb begin
      state_in = state_ff;
      second_in = second_ff;
      rv_in = rv_ff & rsp_stall;
      cmd = '0;
      case (state_ff)
         S_IDLE: if (req_valid && !rv_ff) begin
            cmd.load = 1'b1; state_in = S_MUL;
         end
         S_MUL: begin cmd.mul_step = 1'b1; state_in = S_SUM; end
         S_SUM: begin cmd.sum_step = 1'b1; state_in = S_CHK; end
         S_CHK: begin
            if (status.den_zero || status.num_zero) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               cmd.gcd_init = 1'b1; state_in = S_GCD;
            end
         end
         S_GCD: if (status.gcd_done) state_in = S_DIVI;
                else cmd.gcd_step = 1'b1;
         S_DIVI: begin cmd.div_init = 1'b1; state_in = S_DIV; end
         S_DIV: if (status.div_done) begin
            cmd.finish = 1'b1;
            second_in = ~second_ff;
            state_in = second_ff ? S_OUT : S_DIVI;
         end else cmd.div_step = 1'b1;
         S_OUT: begin rv_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; second_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; second_ff <= second_in; rv_ff <= rv_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE) | rv_ff;
   assign rsp_valid = rv_ff;

   `ASSERT_IMP(a_no_accept_busy, clock, reset, rv_ff, req_stall)
   `ASSERT_NEXT(a_load_to_mul, clock, reset, cmd.load, state_ff == S_MUL)
   `ASSERT_IMP(a_gcd_idle, clock, reset, cmd.gcd_step, !cmd.div_step)
endmodule
`default_nettype wire

// File: rtl/core/rational_arith_reduce.sv
// one word in, one word out; no overlap between words
// steps: load, multiply, sum, check, gcd loop, two divisions, output
// gcd: binary gcd
// a new word waits for the last response; time per word is set by the gcd loop
// and two restoring dividers sharing one shift-subtract unit
// synchronous reset clears the controller and valid
`default_nettype none
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = rar_pkg::OperandWidthDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_mode,
   input  wire logic [15:0]  req_a_num,
   input  wire logic [15:0]  req_a_den,
   input  wire logic [15:0]  req_b_num,
   input  wire logic [15:0]  req_b_den,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic signed [32:0] rsp_res_num,
   output logic [30:0]       rsp_res_den,
   output logic              rsp_div_zero
);
   rar_pkg::cmd_type    cmd;
   rar_pkg::status_type status;

   rar_control u_ctl (.clock, .reset, .req_valid, .req_stall, .rsp_valid,
                      .rsp_stall, .cmd, .status);
   rar_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (.clock, .reset, .cmd,
      .status, .req_mode, .req_a_num, .req_a_den, .req_b_num, .req_b_den,
      .rsp_res_num, .rsp_res_den, .rsp_div_zero);
endmodule
`default_nettype wire
